@@ hw/rtl/bbds_pkg.sv @@
package bbds_pkg;

	// Line store depth: the widest frame the block can hold.
	localparam int LINE_DEPTH = 4096;
	localparam int COL_W = $clog2(LINE_DEPTH);
	localparam int ROW_W = 16;

	localparam int WIDTH_REG_W = 13;
	localparam int HEIGHT_REG_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Bit positions of the result kinds an item can cause, in delivery order.
	localparam int RES_CENTER = 0;
	localparam int RES_EDGE = 1;
	localparam int RES_BOTTOM = 2;
	localparam int RES_CORNER = 3;
	localparam int RES_KINDS = 4;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		rgb_t ctr;
		rgb_t smooth;
		rgb_t mid;
		rgb_t prev;
		rgb_t cur;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [RES_KINDS-1:0] kinds;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} q_push_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} q_head_t;

	// Last column index for a programmed width, with zero and oversize clamped.
	function automatic logic [COL_W-1:0] eff_wm1(input logic [WIDTH_REG_W-1:0] w);
		logic [31:0] wx;
		wx = 32'(w);
		if (wx == 32'd0) begin
			return '0;
		end else if (wx > 32'(LINE_DEPTH)) begin
			return COL_W'(LINE_DEPTH - 1);
		end else begin
			return COL_W'(wx - 32'd1);
		end
	endfunction

	function automatic logic [ROW_W-1:0] eff_hm1(input logic [HEIGHT_REG_W-1:0] h);
		if (h == '0) begin
			return '0;
		end else begin
			return ROW_W'(h - HEIGHT_REG_W'(1));
		end
	endfunction

endpackage

@@ hw/rtl/bbds_if.sv @@
interface bbds_pixel_if;
	logic valid;
	logic ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

interface bbds_result_if;
	logic valid;
	logic ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [15:0] out_row;
	logic [11:0] out_col;
	logic frame_done;
	logic run_end;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_row, output out_col, output frame_done, output run_end, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_row, input out_col, input frame_done, input run_end, output ready);
endinterface

@@ hw/rtl/bbds_front.sv @@
module bbds_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bbds_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bbds_pkg::CFG_DATA_W-1:0] cfg_data,
	bbds_pixel_if.sink pixel,
	input logic [bbds_pkg::QCNT_W-1:0] q_count,
	output bbds_pkg::q_push_t q_push
);

	typedef struct packed {
		bbds_pkg::rgb_t up;
		bbds_pkg::rgb_t mid;
	} line_t;

	typedef struct packed {
		logic [6:0] blue;
		logic [6:0] green;
		logic [6:0] red;
	} csum_t;

	// floor(v/9) for an 8-bit value: 57/512 is close enough to 1/9 over this range.
	function automatic logic [4:0] div9(input logic [7:0] v);
		logic [13:0] p;
		p = 14'(v) * 14'd57;
		return p[13:9];
	endfunction

	function automatic csum_t col_sum(input bbds_pkg::rgb_t a, input bbds_pkg::rgb_t b,
		input bbds_pkg::rgb_t c);
		csum_t s;
		s.red = 7'(div9(a.red)) + 7'(div9(b.red)) + 7'(div9(c.red));
		s.green = 7'(div9(a.green)) + 7'(div9(b.green)) + 7'(div9(c.green));
		s.blue = 7'(div9(a.blue)) + 7'(div9(b.blue)) + 7'(div9(c.blue));
		return s;
	endfunction

	function automatic logic [7:0] add3(input logic [6:0] a, input logic [6:0] b,
		input logic [6:0] c);
		return 8'(a) + 8'(b) + 8'(c);
	endfunction

	localparam int FILL_W = bbds_pkg::QCNT_W + 1;

	// Line stores for rows r-2 and r-1, packed side by side at one address.
	line_t line_mem [bbds_pkg::LINE_DEPTH];

	logic [bbds_pkg::COL_W-1:0] wm1_q;
	logic [bbds_pkg::ROW_W-1:0] hm1_q;
	logic [bbds_pkg::COL_W-1:0] col_q;
	logic [bbds_pkg::ROW_W-1:0] row_q;

	logic [FILL_W-1:0] fill;
	logic en;
	logic acc;
	logic [bbds_pkg::RES_KINDS-1:0] kinds_in;
	logic inner_in;

	logic v_s1;
	bbds_pkg::rgb_t cur_s1;
	logic [bbds_pkg::ROW_W-1:0] row_s1;
	logic [bbds_pkg::COL_W-1:0] col_s1;
	logic [bbds_pkg::RES_KINDS-1:0] kinds_s1;
	logic inner_s1;
	logic byp_s1;
	line_t fwd_s1;
	line_t rd_s1;
	bbds_pkg::rgb_t up_e;
	bbds_pkg::rgb_t mid_e;
	line_t wdata;
	csum_t cs_new;

	logic v_s2;
	csum_t cs_s2;
	bbds_pkg::rgb_t mid_s2;
	bbds_pkg::rgb_t cur_s2;
	logic [bbds_pkg::ROW_W-1:0] row_s2;
	logic [bbds_pkg::COL_W-1:0] col_s2;
	logic [bbds_pkg::RES_KINDS-1:0] kinds_s2;
	logic inner_s2;

	csum_t cs_a_q;
	csum_t cs_b_q;
	bbds_pkg::rgb_t ctr_q;
	bbds_pkg::rgb_t prev_q;
	bbds_pkg::rgb_t smooth;

	// The pipeline moves as one; it holds while the queue could not take
	// the items already in flight plus a new one.
	assign fill = FILL_W'(q_count) + FILL_W'(v_s1) + FILL_W'(v_s2);
	assign en = fill < FILL_W'(bbds_pkg::QUEUE_DEPTH);
	assign pixel.ready = en;
	assign acc = pixel.valid && en;

	always_comb begin
		kinds_in = '0;
		kinds_in[bbds_pkg::RES_CENTER] = (row_q != '0) && (col_q != '0);
		kinds_in[bbds_pkg::RES_EDGE] = (row_q != '0) && (col_q == wm1_q);
		kinds_in[bbds_pkg::RES_BOTTOM] = (row_q == hm1_q) && (col_q != '0);
		kinds_in[bbds_pkg::RES_CORNER] = (row_q == hm1_q) && (col_q == wm1_q);
		inner_in = (row_q > bbds_pkg::ROW_W'(1)) && (col_q > bbds_pkg::COL_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= bbds_pkg::eff_wm1(bbds_pkg::WIDTH_RESET);
			hm1_q <= bbds_pkg::eff_hm1(bbds_pkg::HEIGHT_RESET);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bbds_pkg::REG_FRAME_WIDTH: begin
					wm1_q <= bbds_pkg::eff_wm1(cfg_data[bbds_pkg::WIDTH_REG_W-1:0]);
					col_q <= '0;
					row_q <= '0;
				end
				bbds_pkg::REG_FRAME_HEIGHT: begin
					hm1_q <= bbds_pkg::eff_hm1(cfg_data[bbds_pkg::HEIGHT_REG_W-1:0]);
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			if (col_q == wm1_q) begin
				col_q <= '0;
				row_q <= (row_q == hm1_q) ? '0 : row_q + bbds_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + bbds_pkg::COL_W'(1);
			end
		end
	end

	// Stage 1: line store data arrives. With a one-pixel line the previous
	// item writes the address being read in the same cycle, so it is forwarded.
	always_comb begin
		up_e = byp_s1 ? fwd_s1.up : rd_s1.up;
		mid_e = byp_s1 ? fwd_s1.mid : rd_s1.mid;
		wdata.up = mid_e;
		wdata.mid = cur_s1;
		cs_new = col_sum(up_e, mid_e, cur_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s1) begin
				line_mem[col_s1] <= wdata;
			end
			rd_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_s1.red <= pixel.in_red;
			cur_s1.green <= pixel.in_green;
			cur_s1.blue <= pixel.in_blue;
			row_s1 <= row_q;
			col_s1 <= col_q;
			kinds_s1 <= kinds_in;
			inner_s1 <= inner_in;
			byp_s1 <= v_s1 && (col_s1 == col_q);
			fwd_s1 <= wdata;

			cs_s2 <= cs_new;
			mid_s2 <= mid_e;
			cur_s2 <= cur_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			kinds_s2 <= kinds_s1;
			inner_s2 <= inner_s1;
		end
	end

	// Stage 2: the 3x3 window is kept as two column sums plus the middle and
	// bottom pixels of the previous column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_a_q <= '0;
			cs_b_q <= '0;
			ctr_q <= '0;
			prev_q <= '0;
		end else if (cfg_we && ((cfg_index == bbds_pkg::REG_FRAME_WIDTH) ||
			(cfg_index == bbds_pkg::REG_FRAME_HEIGHT))) begin
			cs_a_q <= '0;
			cs_b_q <= '0;
			ctr_q <= '0;
			prev_q <= '0;
		end else if (en && v_s2) begin
			cs_a_q <= cs_b_q;
			cs_b_q <= cs_s2;
			ctr_q <= mid_s2;
			prev_q <= cur_s2;
		end
	end

	always_comb begin
		if (inner_s2) begin
			smooth.red = add3(cs_a_q.red, cs_b_q.red, cs_s2.red);
			smooth.green = add3(cs_a_q.green, cs_b_q.green, cs_s2.green);
			smooth.blue = add3(cs_a_q.blue, cs_b_q.blue, cs_s2.blue);
		end else begin
			smooth = ctr_q;
		end
		q_push.push = en && v_s2 && (kinds_s2 != '0);
		q_push.job.ctr = ctr_q;
		q_push.job.smooth = smooth;
		q_push.job.mid = mid_s2;
		q_push.job.prev = prev_q;
		q_push.job.cur = cur_s2;
		q_push.job.row = row_s2;
		q_push.job.col = col_s2;
		q_push.job.kinds = kinds_s2;
	end

endmodule

@@ hw/rtl/bbds_queue.sv @@
module bbds_queue (
	input logic clk,
	input logic arst_n,
	input bbds_pkg::q_push_t q_push,
	input logic pop,
	output bbds_pkg::q_head_t head,
	output logic [bbds_pkg::QCNT_W-1:0] count
);

	function automatic logic [bbds_pkg::QPTR_W-1:0] next_ptr(
		input logic [bbds_pkg::QPTR_W-1:0] p);
		if (p == bbds_pkg::QPTR_W'(bbds_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end else begin
			return p + bbds_pkg::QPTR_W'(1);
		end
	endfunction

	bbds_pkg::job_t slot_q [bbds_pkg::QUEUE_DEPTH];
	logic [bbds_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bbds_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bbds_pkg::QCNT_W-1:0] count_q;

	// The front never pushes into a full queue; it counts its own items in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (q_push.push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({q_push.push, pop})
				2'b10: count_q <= count_q + bbds_pkg::QCNT_W'(1);
				2'b01: count_q <= count_q - bbds_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_push.push) begin
			slot_q[wr_ptr_q] <= q_push.job;
		end
	end

	assign head.valid = count_q != '0;
	assign head.job = slot_q[rd_ptr_q];
	assign count = count_q;

endmodule

@@ hw/rtl/bbds_back.sv @@
module bbds_back (
	input logic clk,
	input logic arst_n,
	input bbds_pkg::q_head_t head,
	output logic pop,
	bbds_result_if.source result
);

	function automatic logic [7:0] sharpen_ch(input logic [7:0] v, input logic [7:0] s);
		logic [7:0] d;
		logic [8:0] o;
		d = (v >= s) ? v - s : s - v;
		o = {1'b0, v} + {1'b0, d};
		return o[8] ? 8'hFF : o[7:0];
	endfunction

	logic [bbds_pkg::RES_KINDS-1:0] done_q;
	logic [bbds_pkg::RES_KINDS-1:0] pend;
	logic [bbds_pkg::RES_KINDS-1:0] sel;
	logic [bbds_pkg::RES_KINDS-1:0] rest;
	logic load;
	bbds_pkg::rgb_t sharp;
	bbds_pkg::rgb_t pix;
	logic [bbds_pkg::ROW_W-1:0] row;
	logic [bbds_pkg::COL_W-1:0] col;
	logic [bbds_pkg::ROW_W-1:0] rm1;
	logic [bbds_pkg::COL_W-1:0] cm1;

	logic res_v_q;
	bbds_pkg::rgb_t pix_q;
	logic [bbds_pkg::ROW_W-1:0] row_q;
	logic [bbds_pkg::COL_W-1:0] col_q;
	logic frame_done_q;
	logic run_end_q;

	// Results of the head item go out lowest kind first, one per cycle while the result port is not stalled.
	always_comb begin
		pend = head.job.kinds & ~done_q;
		sel = pend & (~pend + bbds_pkg::RES_KINDS'(1));
		rest = pend & ~sel;
		load = head.valid && (!res_v_q || result.ready);
		pop = load && (rest == '0);

		sharp.red = sharpen_ch(head.job.ctr.red, head.job.smooth.red);
		sharp.green = sharpen_ch(head.job.ctr.green, head.job.smooth.green);
		sharp.blue = sharpen_ch(head.job.ctr.blue, head.job.smooth.blue);
		rm1 = head.job.row - bbds_pkg::ROW_W'(1);
		cm1 = head.job.col - bbds_pkg::COL_W'(1);

		if (sel[bbds_pkg::RES_CENTER]) begin
			pix = sharp;
			row = rm1;
			col = cm1;
		end else if (sel[bbds_pkg::RES_EDGE]) begin
			pix = head.job.mid;
			row = rm1;
			col = head.job.col;
		end else if (sel[bbds_pkg::RES_BOTTOM]) begin
			pix = head.job.prev;
			row = head.job.row;
			col = cm1;
		end else begin
			pix = head.job.cur;
			row = head.job.row;
			col = head.job.col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= pop ? '0 : (done_q | sel);
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_q <= pix;
			row_q <= row;
			col_q <= col;
			frame_done_q <= sel[bbds_pkg::RES_CORNER];
			run_end_q <= rest == '0;
		end
	end

	assign result.valid = res_v_q;
	assign result.out_red = pix_q.red;
	assign result.out_green = pix_q.green;
	assign result.out_blue = pix_q.blue;
	assign result.out_row = row_q;
	assign result.out_col = col_q;
	assign result.frame_done = frame_done_q;
	assign result.run_end = run_end_q;

endmodule

@@ hw/rtl/box_blur_detail_sharpen.sv @@
// 3x3 box-blur sharpener for an RGB raster stream. One pixel item is taken per
// cycle while the four-entry job queue between the pixel pipeline and the result
// stage has room; the single result port sends one item per cycle while the
// receiver is ready. Each row past the first gives one result per pixel, so a
// steady stream runs at one pixel per cycle, while the last row gives two results
// per pixel, four on its final pixel, and is paced by that one result port. The
// two line stores sit in one 4096 x 48 memory, read and written once per cycle
// while the pipeline is not held, and need no clearing pass. Writing frame_width
// or frame_height restarts the frame at row 0, column 0.
module box_blur_detail_sharpen (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bbds_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bbds_pkg::CFG_DATA_W-1:0] cfg_data,
	bbds_pixel_if.sink pixel,
	bbds_result_if.source result
);

	bbds_pkg::q_push_t q_push;
	bbds_pkg::q_head_t q_head;
	logic [bbds_pkg::QCNT_W-1:0] q_count;
	logic q_pop;

	bbds_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pixel),
		.q_count(q_count),
		.q_push(q_push)
	);

	bbds_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.q_push(q_push),
		.pop(q_pop),
		.head(q_head),
		.count(q_count)
	);

	bbds_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(q_head),
		.pop(q_pop),
		.result(result)
	);

endmodule

@@ hw/rtl/bbds_checker.sv @@
module bbds_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bbds_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bbds_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic pixel_valid,
	input logic pixel_ready,
	input logic res_valid,
	input logic res_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [15:0] out_row,
	input logic [11:0] out_col,
	input logic frame_done,
	input logic run_end
);

	logic seen_q;
	logic [bbds_pkg::COL_W-1:0] wm1_q;
	logic [bbds_pkg::ROW_W-1:0] hm1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			wm1_q <= bbds_pkg::eff_wm1(bbds_pkg::WIDTH_RESET);
			hm1_q <= bbds_pkg::eff_hm1(bbds_pkg::HEIGHT_RESET);
		end else begin
			if (pixel_valid && pixel_ready) begin
				seen_q <= 1'b1;
			end
			if (cfg_we && (cfg_index == bbds_pkg::REG_FRAME_WIDTH)) begin
				wm1_q <= bbds_pkg::eff_wm1(cfg_data[bbds_pkg::WIDTH_REG_W-1:0]);
			end
			if (cfg_we && (cfg_index == bbds_pkg::REG_FRAME_HEIGHT)) begin
				hm1_q <= bbds_pkg::eff_hm1(cfg_data[bbds_pkg::HEIGHT_REG_W-1:0]);
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
		$stable({out_red, out_green, out_blue, out_row, out_col, frame_done, run_end}))
		else $error("result item changed while stalled");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> run_end)
		else $error("frame end result is not the last of its run");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> seen_q)
		else $error("result item before any pixel item");

	a_done_corner: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> (out_col == wm1_q) && (out_row == hm1_q))
		else $error("frame end flagged away from the last pixel");

endmodule

bind box_blur_detail_sharpen bbds_checker u_bbds_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_we(cfg_we),
	.cfg_index(cfg_index),
	.cfg_data(cfg_data),
	.pixel_valid(pixel.valid),
	.pixel_ready(pixel.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.out_red(result.out_red),
	.out_green(result.out_green),
	.out_blue(result.out_blue),
	.out_row(result.out_row),
	.out_col(result.out_col),
	.frame_done(result.frame_done),
	.run_end(result.run_end)
);

@@ tb/sv/box_blur_detail_sharpen_test.sv @@
module box_blur_detail_sharpen_test;

	// Indexes past the two real registers; the block must ignore writes to them.
	localparam logic [bbds_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [bbds_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [15:0] row;
		logic [11:0] col;
		logic frame_done;
		logic run_end;
	} sharp_px_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bbds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bbds_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic px_valid = 1'b0;
	bbds_pkg::rgb_t px_data = '0;
	logic rs_ready = 1'b0;

	bbds_pixel_if pix_bus();
	bbds_result_if res_bus();

	assign pix_bus.valid = px_valid;
	assign pix_bus.in_red = px_data.red;
	assign pix_bus.in_green = px_data.green;
	assign pix_bus.in_blue = px_data.blue;
	assign res_bus.ready = rs_ready;

	box_blur_detail_sharpen uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pix_bus),
		.result(res_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bbds_pkg::rgb_t raster_pixels[$];
	sharp_px_t sharp_due[$];
	int mismatches = 0;

	// Predictor state.
	bbds_pkg::rgb_t upper_line [bbds_pkg::LINE_DEPTH];
	bbds_pkg::rgb_t middle_line [bbds_pkg::LINE_DEPTH];
	bbds_pkg::rgb_t win_px [3][3];
	int unsigned row_pos;
	int unsigned col_pos;
	logic [bbds_pkg::WIDTH_REG_W-1:0] width_reg;
	logic [bbds_pkg::HEIGHT_REG_W-1:0] height_reg;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void restart_frame();
		int a, b;
		for (a = 0; a < 3; a++) begin
			for (b = 0; b < 3; b++) begin
				win_px[a][b] = '0;
			end
		end
		row_pos = 0;
		col_pos = 0;
	endfunction

	function automatic void reset_predictor();
		int i;
		for (i = 0; i < bbds_pkg::LINE_DEPTH; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		width_reg = bbds_pkg::WIDTH_RESET;
		height_reg = bbds_pkg::HEIGHT_RESET;
		restart_frame();
	endfunction

	function automatic void apply_register(input logic [bbds_pkg::CFG_IDX_W-1:0] idx,
		input logic [bbds_pkg::CFG_DATA_W-1:0] data);
		if (idx == bbds_pkg::REG_FRAME_WIDTH) begin
			width_reg = data[bbds_pkg::WIDTH_REG_W-1:0];
			restart_frame();
		end else if (idx == bbds_pkg::REG_FRAME_HEIGHT) begin
			height_reg = data;
			restart_frame();
		end
	endfunction

	// Each channel sums floor(v/9) over the window, so it never exceeds 252.
	function automatic bbds_pkg::rgb_t box_smooth();
		bbds_pkg::rgb_t s;
		int k, a, b, acc;
		for (k = 0; k < 3; k++) begin
			acc = 0;
			for (a = 0; a < 3; a++) begin
				for (b = 0; b < 3; b++) begin
					acc += win_px[a][b][8*k +: 8] / 9;
				end
			end
			s[8*k +: 8] = acc[7:0];
		end
		return s;
	endfunction

	function automatic bbds_pkg::rgb_t sharpen(input bbds_pkg::rgb_t px,
		input bbds_pkg::rgb_t sm);
		bbds_pkg::rgb_t o;
		int k, v, s, d;
		for (k = 0; k < 3; k++) begin
			v = px[8*k +: 8];
			s = sm[8*k +: 8];
			d = (v >= s) ? v - s : s - v;
			o[8*k +: 8] = (v + d > 255) ? 8'd255 : 8'(v + d);
		end
		return o;
	endfunction

	function automatic sharp_px_t pack_result(input bbds_pkg::rgb_t px, input int unsigned r,
		input int unsigned c);
		sharp_px_t p;
		p.red = px.red;
		p.green = px.green;
		p.blue = px.blue;
		p.row = 16'(r);
		p.col = 12'(c);
		p.frame_done = 1'b0;
		p.run_end = 1'b0;
		return p;
	endfunction

	task automatic predict_sharpen(input bbds_pkg::rgb_t cur);
		int unsigned w, h, r, c;
		int a, b, n;
		bbds_pkg::rgb_t up, mid, ctr, sm;
		sharp_px_t outs [4];
		n = 0;
		w = (width_reg == 0) ? 1 : width_reg;
		if (w > bbds_pkg::LINE_DEPTH) begin
			w = bbds_pkg::LINE_DEPTH;
		end
		h = (height_reg == 0) ? 1 : height_reg;
		if (col_pos >= w) begin
			col_pos = 0;
		end
		if (row_pos >= h) begin
			row_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		up = upper_line[c];
		mid = middle_line[c];
		for (a = 0; a < 2; a++) begin
			for (b = 0; b < 3; b++) begin
				win_px[a][b] = win_px[a+1][b];
			end
		end
		win_px[2][0] = up;
		win_px[2][1] = mid;
		win_px[2][2] = cur;
		upper_line[c] = mid;
		middle_line[c] = cur;

		if (r >= 1 && c >= 1) begin
			ctr = win_px[1][1];
			sm = (r >= 2 && c >= 2) ? box_smooth() : ctr;
			outs[n] = pack_result(sharpen(ctr, sm), r - 1, c - 1);
			n++;
		end
		// The right column and the bottom row pass through unchanged.
		if (r >= 1 && c == w - 1) begin
			outs[n] = pack_result(mid, r - 1, w - 1);
			n++;
		end
		if (r == h - 1 && c >= 1) begin
			outs[n] = pack_result(win_px[1][2], h - 1, c - 1);
			n++;
		end
		if (r == h - 1 && c == w - 1) begin
			outs[n] = pack_result(cur, h - 1, w - 1);
			outs[n].frame_done = 1'b1;
			n++;
		end
		if (n > 0) begin
			outs[n-1].run_end = 1'b1;
		end
		for (a = 0; a < n; a++) begin
			sharp_due.push_back(outs[a]);
		end

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
			end
		end
		col_pos = c;
		row_pos = r;
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!px_valid || pix_bus.ready) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (gap_left > 0 || raster_pixels.size() == 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end
				px_valid <= 1'b0;
			end else begin
				px_data <= raster_pixels.pop_front();
				px_valid <= 1'b1;
				burst_left--;
			end
		end
	end

	// Receiver: a stall mode that changes now and then, plus one long hold-off.
	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;
	logic [7:0] stall_pattern = '0;
	int hold_left = 0;
	bit squeeze_armed = 1'b0;
	bit squeeze_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 120);
				stall_pattern = 8'($urandom);
			end
			mode_left--;
			stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
			if (hold_left > 0) begin
				hold_left--;
				rs_ready <= 1'b0;
			end else if (squeeze_armed && !squeeze_done && px_valid) begin
				hold_left = 80;
				squeeze_done = 1'b1;
				rs_ready <= 1'b0;
			end else begin
				case (stall_mode)
					STALL_NONE: rs_ready <= 1'b1;
					STALL_LIGHT: rs_ready <= ($urandom_range(0, 3) != 0);
					STALL_HEAVY: rs_ready <= ($urandom_range(0, 3) == 0);
					default: rs_ready <= stall_pattern[0];
				endcase
			end
		end
	end

	// Monitor: register writes and accepted pixels feed the predictor, then each
	// accepted result item is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : monitor
		sharp_px_t got, want;
		if (!arst_n) begin
			reset_predictor();
			sharp_due.delete();
		end else begin
			if (cfg_we) begin
				apply_register(cfg_index, cfg_data);
			end
			if (px_valid && pix_bus.ready) begin
				predict_sharpen(px_data);
			end
			if (res_bus.valid && rs_ready) begin
				got.red = res_bus.out_red;
				got.green = res_bus.out_green;
				got.blue = res_bus.out_blue;
				got.row = res_bus.out_row;
				got.col = res_bus.out_col;
				got.frame_done = res_bus.frame_done;
				got.run_end = res_bus.run_end;
				if (sharp_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result row %0d col %0d",
						got.row, got.col));
				end else begin
					want = sharp_due.pop_front();
					if (got !== want) begin
						report_mismatch($sformatf(
							"got rgb %h%h%h r%0d c%0d fd%b re%b, want rgb %h%h%h r%0d c%0d fd%b re%b",
							got.red, got.green, got.blue, got.row, got.col,
							got.frame_done, got.run_end, want.red, want.green, want.blue,
							want.row, want.col, want.frame_done, want.run_end));
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [bbds_pkg::CFG_IDX_W-1:0] idx,
		input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bbds_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until every pixel is taken and every result has come back, then lets
	// the pipeline settle for items that produce no result.
	task automatic await_idle(input int settle);
		while (raster_pixels.size() != 0 || px_valid || sharp_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (settle) @(negedge clk);
	endtask

	function automatic bbds_pkg::rgb_t pick_pixel();
		bbds_pkg::rgb_t p;
		int k;
		case ($urandom_range(0, 7))
			0, 1: begin
				for (k = 0; k < 3; k++) begin
					p[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
			end
			2: begin
				for (k = 0; k < 3; k++) begin
					p[8*k +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 20))
						: 8'($urandom_range(235, 255));
				end
			end
			default: p = 24'($urandom);
		endcase
		return p;
	endfunction

	initial begin : stimulus
		int i, w, h, n, random_sent;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 3x3 frames: a dark center among saturated neighbours, then a bright
		// center among dark ones that saturates the output.
		write_reg(bbds_pkg::REG_FRAME_WIDTH, 3);
		write_reg(bbds_pkg::REG_FRAME_HEIGHT, 3);
		for (i = 0; i < 9; i++) begin
			raster_pixels.push_back((i == 4) ? 24'h000000 : 24'hFFFFFF);
		end
		for (i = 0; i < 9; i++) begin
			raster_pixels.push_back((i == 4) ? 24'h7F80FF : 24'h000000);
		end
		await_idle(12);

		// Zero sizes act as one: every pixel is a whole frame.
		write_reg(bbds_pkg::REG_FRAME_WIDTH, 0);
		write_reg(bbds_pkg::REG_FRAME_HEIGHT, 0);
		raster_pixels.push_back(24'h0180FE);
		raster_pixels.push_back(24'hFE7F01);
		await_idle(12);

		// A write to an unknown index between two rows must not restart the frame.
		write_reg(bbds_pkg::REG_FRAME_HEIGHT, 2);
		raster_pixels.push_back(24'h55AA55);
		await_idle(12);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		raster_pixels.push_back(24'hAA55AA);
		await_idle(12);

		// Tallest frame, left unfinished; the next write restarts it.
		write_reg(bbds_pkg::REG_FRAME_WIDTH, 2);
		write_reg(bbds_pkg::REG_FRAME_HEIGHT, 65535);
		for (i = 0; i < 4; i++) begin
			raster_pixels.push_back(pick_pixel());
		end
		await_idle(12);

		// Oversize width clamps to the line store depth: the start of one long row.
		write_reg(bbds_pkg::REG_FRAME_WIDTH, 16'hFFFF);
		write_reg(bbds_pkg::REG_FRAME_HEIGHT, 1);
		for (i = 0; i < 6; i++) begin
			raster_pixels.push_back(pick_pixel());
		end
		await_idle(12);

		// First random frame carries the long receiver hold-off.
		write_reg(bbds_pkg::REG_FRAME_WIDTH, 8);
		write_reg(bbds_pkg::REG_FRAME_HEIGHT, 6);
		w = 8;
		h = 6;
		squeeze_armed = 1'b1;
		for (i = 0; i < 48; i++) begin
			raster_pixels.push_back(pick_pixel());
		end
		random_sent = 48;

		while (random_sent < 135) begin
			await_idle(12);
			case ($urandom_range(0, 3))
				0: begin
					w = $urandom_range(1, 9);
					write_reg(bbds_pkg::REG_FRAME_WIDTH, w);
				end
				1: begin
					h = $urandom_range(1, 6);
					write_reg(bbds_pkg::REG_FRAME_HEIGHT, h);
				end
				2: begin
					write_reg(REG_SPARE_HI, $urandom);
					w = $urandom_range(1, 9);
					h = $urandom_range(1, 6);
					write_reg(bbds_pkg::REG_FRAME_HEIGHT, h);
					write_reg(bbds_pkg::REG_FRAME_WIDTH, w);
				end
				default: begin
					w = $urandom_range(1, 9);
					h = $urandom_range(1, 6);
					write_reg(bbds_pkg::REG_FRAME_WIDTH, w);
					write_reg(bbds_pkg::REG_FRAME_HEIGHT, h);
				end
			endcase
			// Mostly whole frames, sometimes a frame cut short by the next write.
			if ($urandom_range(0, 3) != 0) begin
				n = w * h * $urandom_range(1, 2);
			end else begin
				n = $urandom_range(1, w * h + w);
			end
			for (i = 0; i < n; i++) begin
				raster_pixels.push_back(pick_pixel());
			end
			random_sent += n;
		end

		await_idle(20);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

endmodule
